// ===== hw/rtl/yrgb_pkg.sv =====
// Shared types, constants and helpers of the YCbCr to BGR group converter.
// Used by every module of the converter; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package yrgb_pkg;

	// Default frame limits
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Reset values of the frame size registers
	localparam logic [11:0] RST_WIDTH  = 12'd640;
	localparam logic [11:0] RST_HEIGHT = 12'd480;

	// Group queue between front and back (power of two)
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// Signed Q1.16 BT.601 coefficients
	localparam logic signed [17:0] K_RV = 18'sd91881;
	localparam logic signed [17:0] K_GU = -18'sd22553;
	localparam logic signed [17:0] K_GV = -18'sd46801;
	localparam logic signed [17:0] K_BU = 18'sd116129;

	// Channel sum in signed Q10.16 and its clip bounds
	typedef logic signed [26:0] term_t;
	localparam term_t CLIP_HIGH = 27'sh0ffffff;
	localparam term_t CLIP_LOW  = 27'sh000ffff;

	// Register map, one word per register
	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	// Format codes
	localparam logic FMT_420 = 1'b0;
	localparam logic FMT_411 = 1'b1;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic        mode;
		logic [11:0] width;
		logic [11:0] height;
	} cfg_t;

	// One classified group waiting for the back part
	typedef struct packed {
		logic [3:0][7:0] luma;
		term_t           bt;
		term_t           gt;
		term_t           rt;
		logic [10:0]     x;
		logic [10:0]     y;
		logic            mode;
		logic            frame_wrap;
	} entry_t;

	// Clip a signed Q10.16 sum to one byte
	function automatic logic [7:0] clip_byte(input term_t s);
		logic [7:0] r;
		if (s > CLIP_HIGH) begin
			r = 8'hff;
		end else if (s <= CLIP_LOW) begin
			r = 8'h00;
		end else begin
			r = s[23:16];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yuv_to_rgb_block_converter_top.sv =====
// YCbCr to BGR group converter: one group in, four clipped pixels out.
// The first pixel is registered at the output after the group has passed the front
// stage 1 register and the queue; the other three follow unless pixel_stall holds them.
// Group rate is set by the single pixel output register, which sends four pixels per group.
// A two-entry queue lets the input take further groups while pixels drain.
// Reset clears position counters, stage 1 valid, queue and output valid; registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

module yuv_to_rgb_block_converter_top #(
	parameter int MAX_WIDTH  = yrgb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yrgb_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	input  wire logic        group_valid,
	output      logic        group_stall,
	input  wire logic [7:0]  luma_a,
	input  wire logic [7:0]  luma_b,
	input  wire logic [7:0]  luma_c,
	input  wire logic [7:0]  luma_d,
	input  wire logic [7:0]  chroma_u,
	input  wire logic [7:0]  chroma_v,
	output      logic        pixel_valid,
	input  wire logic        pixel_stall,
	output      logic [10:0] pixel_x,
	output      logic [10:0] pixel_y,
	output      logic [7:0]  blue,
	output      logic [7:0]  green,
	output      logic [7:0]  red,
	output      logic        group_last,
	output      logic        frame_end
);

	yrgb_pkg::cfg_t   cfg;
	yrgb_pkg::entry_t push_data, head;
	logic             push, full, pop, empty;

	yrgb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	yrgb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.group_valid (group_valid),
		.group_stall (group_stall),
		.luma_a      (luma_a),
		.luma_b      (luma_b),
		.luma_c      (luma_c),
		.luma_d      (luma_d),
		.chroma_u    (chroma_u),
		.chroma_v    (chroma_v),
		.q_full      (full),
		.q_push      (push),
		.q_data      (push_data)
	);

	yrgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	yrgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.group_last  (group_last),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/yrgb_regs.sv =====
// Configuration register file with an APB-style access port.
// Depends on yrgb_pkg for the register map and the cfg_t type.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready,
	output      yrgb_pkg::cfg_t    cfg
);

	yrgb_pkg::cfg_t   cfg_q;
	yrgb_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = yrgb_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write registers, drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= yrgb_pkg::FMT_420;
			cfg_q.width  <= yrgb_pkg::RST_WIDTH;
			cfg_q.height <= yrgb_pkg::RST_HEIGHT;
		end else if (wr_en) begin
			case (idx)
				yrgb_pkg::REG_FORMAT: cfg_q.mode   <= pwdata[0];
				yrgb_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[11:0];
				yrgb_pkg::REG_HEIGHT: cfg_q.height <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			yrgb_pkg::REG_FORMAT: prdata = {31'd0, cfg_q.mode};
			yrgb_pkg::REG_WIDTH:  prdata = {20'd0, cfg_q.width};
			yrgb_pkg::REG_HEIGHT: prdata = {20'd0, cfg_q.height};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/yrgb_front.sv =====
// Front part: accepts chroma groups, tracks the group position, classifies
// row and frame wrap and forms the chroma terms. Depends on yrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_front #(
	parameter int MAX_WIDTH  = yrgb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yrgb_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire yrgb_pkg::cfg_t   cfg,
	input  wire logic             group_valid,
	output      logic             group_stall,
	input  wire logic [7:0]       luma_a,
	input  wire logic [7:0]       luma_b,
	input  wire logic [7:0]       luma_c,
	input  wire logic [7:0]       luma_d,
	input  wire logic [7:0]       chroma_u,
	input  wire logic [7:0]       chroma_v,
	input  wire logic             q_full,
	output      logic             q_push,
	output      yrgb_pkg::entry_t q_data
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int NW = ((CW > 12) ? CW : 12) + 1;
	localparam int NH = ((HW > 12) ? HW : 12) + 1;

	// Group position
	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;

	// Stage 1 request
	logic            valid_s1;
	logic [3:0][7:0] luma_s1;
	logic [7:0]      cu_s1;
	logic [7:0]      cv_s1;
	logic [10:0]     x_s1;
	logic [10:0]     y_s1;
	logic            mode_s1;
	logic            fwrap_s1;

	logic [NW-1:0] w_lim, gw, col_sum;
	logic [NH-1:0] h_lim, gh, row_sum;
	logic          too_small, row_wrap, frame_wrap;
	logic          adv_s1, accept, keep;

	logic signed [7:0] u_s, v_s;

	// Classify against the saturated frame size
	assign w_lim = (NW'(cfg.width) > NW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : NW'(cfg.width);
	assign h_lim = (NH'(cfg.height) > NH'(MAX_HEIGHT)) ? NH'(MAX_HEIGHT) : NH'(cfg.height);
	assign gw    = (cfg.mode == yrgb_pkg::FMT_411) ? NW'(4) : NW'(2);
	assign gh    = (cfg.mode == yrgb_pkg::FMT_411) ? NH'(1) : NH'(2);

	assign col_sum    = NW'(col_q) + gw;
	assign row_sum    = NH'(row_q) + gh;
	assign too_small  = (w_lim < gw) || (h_lim < gh);
	assign row_wrap   = col_sum > (w_lim - gw);
	assign frame_wrap = row_wrap && (row_sum > (h_lim - gh));

	// Handshake: hold the input while stage 1 cannot drain into the queue
	assign adv_s1      = !valid_s1 || !q_full;
	assign group_stall = !adv_s1;
	assign accept      = group_valid && !group_stall;
	assign keep        = !too_small;

	// Advance the group position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && keep) begin
			if (!row_wrap) begin
				col_q <= CW'(col_sum);
			end else begin
				col_q <= '0;
				row_q <= frame_wrap ? '0 : HW'(row_sum);
			end
		end
	end

	// Stage 1 valid; drop groups that do not fit the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept && keep;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1  <= {luma_d, luma_c, luma_b, luma_a};
			cu_s1    <= chroma_u;
			cv_s1    <= chroma_v;
			x_s1     <= 11'(col_q);
			y_s1     <= 11'(row_q);
			mode_s1  <= cfg.mode;
			fwrap_s1 <= frame_wrap;
		end
	end

	// Remove the chroma offset and form the channel terms
	assign u_s = signed'({~cu_s1[7], cu_s1[6:0]});
	assign v_s = signed'({~cv_s1[7], cv_s1[6:0]});

	always_comb begin
		q_data            = '0;
		q_data.luma       = luma_s1;
		q_data.rt         = v_s * yrgb_pkg::K_RV;
		q_data.gt         = u_s * yrgb_pkg::K_GU + v_s * yrgb_pkg::K_GV;
		q_data.bt         = u_s * yrgb_pkg::K_BU;
		q_data.x          = x_s1;
		q_data.y          = y_s1;
		q_data.mode       = mode_s1;
		q_data.frame_wrap = fwrap_s1;
	end

	assign q_push = valid_s1 && !q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/yrgb_queue.sv =====
// Short group queue between the front and back parts.
// Depends on yrgb_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire yrgb_pkg::entry_t push_data,
	output      logic             full,
	input  wire logic             pop,
	output      yrgb_pkg::entry_t head,
	output      logic             empty
);

	localparam int AW = yrgb_pkg::QAW;

	yrgb_pkg::entry_t slot_q [yrgb_pkg::QDEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      count_q;

	assign full  = count_q == (AW + 1)'(yrgb_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_q];

	// Store the pushed group
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("group pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("group popped from an empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/yrgb_back.sv =====
// Back part: expands each queued group into four pixels, one per cycle unless
// pixel_stall holds the registered output. Depends on yrgb_pkg for the entry and clip.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire yrgb_pkg::entry_t head,
	input  wire logic             empty,
	output      logic             pop,
	output      logic             pixel_valid,
	input  wire logic             pixel_stall,
	output      logic [10:0]      pixel_x,
	output      logic [10:0]      pixel_y,
	output      logic [7:0]       blue,
	output      logic [7:0]       green,
	output      logic [7:0]       red,
	output      logic             group_last,
	output      logic             frame_end
);

	logic [1:0]  k_q;
	logic        valid_q;
	logic [10:0] x_q, y_q;
	logic [7:0]  blue_q, green_q, red_q;
	logic        last_q, fend_q;

	logic            adv, fire;
	yrgb_pkg::term_t ys;
	logic [10:0]     px, py;

	// Output register drains or is empty
	assign adv  = !valid_q || !pixel_stall;
	assign fire = adv && !empty;
	assign pop  = fire && (k_q == 2'd3);

	// Pixel k of the head group
	assign ys = signed'({3'b000, head.luma[k_q], 16'h0000});
	assign px = (head.mode == yrgb_pkg::FMT_411) ? head.x + 11'(k_q) : head.x + 11'(k_q[0]);
	assign py = (head.mode == yrgb_pkg::FMT_411) ? head.y : head.y + 11'(k_q[1]);

	// Pixel counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= !empty;
			end
			if (fire) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			x_q     <= px;
			y_q     <= py;
			blue_q  <= yrgb_pkg::clip_byte(head.bt + ys);
			green_q <= yrgb_pkg::clip_byte(head.gt + ys);
			red_q   <= yrgb_pkg::clip_byte(head.rt + ys);
			last_q  <= k_q == 2'd3;
			fend_q  <= (k_q == 2'd3) && head.frame_wrap;
		end
	end

	assign pixel_valid = valid_q;
	assign pixel_x     = x_q;
	assign pixel_y     = y_q;
	assign blue        = blue_q;
	assign green       = green_q;
	assign red         = red_q;
	assign group_last  = last_q;
	assign frame_end   = fend_q;

	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != 2'd0) |-> !empty)
		else $error("group left the queue before its fourth pixel");

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && fend_q) |-> last_q)
		else $error("frame end on a pixel that is not last of its group");

endmodule

`default_nettype wire
